// ===== src/ima_pkg.sv =====
// ----------------------------------------------------------------------------
// ima_pkg
// Shared widths, codes and word types for the integer matrix ALU.
// ----------------------------------------------------------------------------
package ima_pkg;

   // Field widths
   localparam int MAX_DIM_DEF = 8;
   localparam int IDX_W       = 3;
   localparam int DIM_W       = 4;
   localparam int OP_W        = 3;
   localparam int VAL_W       = 32;
   localparam int ACT_W       = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int TDATA_W     = 40;

   // Queue depths
   localparam int CMD_DEPTH = 4;
   localparam int OUT_DEPTH = 4;

   // Operation codes
   localparam logic [OP_W-1:0] OP_ADD       = 3'd0;
   localparam logic [OP_W-1:0] OP_SUB       = 3'd1;
   localparam logic [OP_W-1:0] OP_MUL       = 3'd2;
   localparam logic [OP_W-1:0] OP_TRANSPOSE = 3'd3;
   localparam logic [OP_W-1:0] OP_SCALE     = 3'd4;

   // Request actions
   localparam logic [ACT_W-1:0] ACT_WRITE_A = 2'd0;
   localparam logic [ACT_W-1:0] ACT_WRITE_B = 2'd1;
   localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OPERATION = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_A    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_A    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_B    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_B    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE     = 3'd5;

   // Command kinds passed from front to back
   typedef enum logic [1:0] {
      KIND_WRITE_A,
      KIND_WRITE_B,
      KIND_RUN,
      KIND_ERROR
   } kind_type;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [DIM_W-1:0] rows_a;
      logic [DIM_W-1:0] cols_a;
      logic [DIM_W-1:0] rows_b;
      logic [DIM_W-1:0] cols_b;
      logic [VAL_W-1:0] scale;
   } cfg_type;

   typedef struct packed {
      kind_type         kind;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic [VAL_W-1:0] value;
   } cmd_type;

   typedef struct packed {
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic [VAL_W-1:0] value;
      logic             last;
      logic             status;
   } rsp_type;

endpackage

// ===== src/ima_ram.sv =====
// ----------------------------------------------------------------------------
// ima_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ima_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/ima_queue.sv =====
// ----------------------------------------------------------------------------
// ima_queue
// Small register FIFO with a fill count; callers never push when full.
// ----------------------------------------------------------------------------
module ima_queue #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             valid,
   output logic             full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed word
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= din;
      end
   end

   assign dout  = slot_ff[rd_ptr_ff];
   assign valid = (count_ff != '0);
   assign full  = (count_ff == CNT_W'(DEPTH));

endmodule

// ===== src/ima_front.sv =====
// ----------------------------------------------------------------------------
// ima_front
// Holds the configuration registers, classifies request words and checks
// the dimensions of compute commands before they are queued.
// ----------------------------------------------------------------------------
module ima_front #(
   parameter int MAX_DIM = ima_pkg::MAX_DIM_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [ima_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ima_pkg::VAL_W-1:0]      csr_wdata,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [ima_pkg::ACT_W-1:0]      req_action,
   input  logic [ima_pkg::IDX_W-1:0]      req_row,
   input  logic [ima_pkg::IDX_W-1:0]      req_col,
   input  logic [ima_pkg::VAL_W-1:0]      req_value,
   input  logic                           cmd_full,
   output logic                           cmd_push,
   output ima_pkg::cmd_type               cmd,
   output ima_pkg::cfg_type               cfg
);

   import ima_pkg::*;

   localparam logic [DIM_W-1:0] MAX_D = DIM_W'(MAX_DIM);

   function automatic logic dim_ok(input logic [DIM_W-1:0] d);
      return (d != '0) && (d <= MAX_D);
   endfunction

   logic [OP_W-1:0]  op_ff, op_in;
   logic [DIM_W-1:0] rows_a_ff, rows_a_in;
   logic [DIM_W-1:0] cols_a_ff, cols_a_in;
   logic [DIM_W-1:0] rows_b_ff, rows_b_in;
   logic [DIM_W-1:0] cols_b_ff, cols_b_in;
   logic [VAL_W-1:0] scale_ff, scale_in;
   logic             in_range;
   logic             dims_ok;
   logic             keep;

   // Register writes
   always_comb begin
      op_in     = op_ff;
      rows_a_in = rows_a_ff;
      cols_a_in = cols_a_ff;
      rows_b_in = rows_b_ff;
      cols_b_in = cols_b_ff;
      scale_in  = scale_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_OPERATION: op_in     = csr_wdata[OP_W-1:0];
            CSR_ROWS_A:    rows_a_in = csr_wdata[DIM_W-1:0];
            CSR_COLS_A:    cols_a_in = csr_wdata[DIM_W-1:0];
            CSR_ROWS_B:    rows_b_in = csr_wdata[DIM_W-1:0];
            CSR_COLS_B:    cols_b_in = csr_wdata[DIM_W-1:0];
            CSR_SCALE:     scale_in  = csr_wdata;
            default:       op_in     = op_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff     <= OP_ADD;
         rows_a_ff <= DIM_W'(1);
         cols_a_ff <= DIM_W'(1);
         rows_b_ff <= DIM_W'(1);
         cols_b_ff <= DIM_W'(1);
         scale_ff  <= VAL_W'(1);
      end else begin
         op_ff     <= op_in;
         rows_a_ff <= rows_a_in;
         cols_a_ff <= cols_a_in;
         rows_b_ff <= rows_b_in;
         cols_b_ff <= cols_b_in;
         scale_ff  <= scale_in;
      end
   end

   assign cfg.op     = op_ff;
   assign cfg.rows_a = rows_a_ff;
   assign cfg.cols_a = cols_a_ff;
   assign cfg.rows_b = rows_b_ff;
   assign cfg.cols_b = cols_b_ff;
   assign cfg.scale  = scale_ff;

   // Check the dimensions that the configured operation uses
   always_comb begin
      dims_ok = dim_ok(rows_a_ff) && dim_ok(cols_a_ff);
      case (op_ff)
         OP_ADD, OP_SUB: begin
            dims_ok = dims_ok && (rows_a_ff == rows_b_ff) && (cols_a_ff == cols_b_ff);
         end
         OP_MUL: begin
            dims_ok = dims_ok && dim_ok(rows_b_ff) && dim_ok(cols_b_ff)
                      && (cols_a_ff == rows_b_ff);
         end
         OP_TRANSPOSE, OP_SCALE: begin
            dims_ok = dims_ok;
         end
         default: begin
            dims_ok = 1'b0;
         end
      endcase
   end

   assign in_range = (DIM_W'(req_row) < MAX_D) && (DIM_W'(req_col) < MAX_D);

   // Classify the word; drop writes with an index of MAX_DIM or more and unused actions
   always_comb begin
      keep      = 1'b0;
      cmd.kind  = KIND_ERROR;
      cmd.row   = req_row;
      cmd.col   = req_col;
      cmd.value = req_value;
      case (req_action)
         ACT_WRITE_A: begin
            keep     = in_range;
            cmd.kind = KIND_WRITE_A;
         end
         ACT_WRITE_B: begin
            keep     = in_range;
            cmd.kind = KIND_WRITE_B;
         end
         ACT_COMPUTE: begin
            keep     = 1'b1;
            cmd.kind = dims_ok ? KIND_RUN : KIND_ERROR;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_tready = !cmd_full;
   assign cmd_push   = req_tvalid && req_tready && keep;

endmodule

// ===== src/ima_back.sv =====
// ----------------------------------------------------------------------------
// ima_back
// Executes queued commands: element writes into the A and B stores, and
// compute runs that walk row, column and inner index through a three-stage
// read / multiply / accumulate pipeline into a credited output queue.
// ----------------------------------------------------------------------------
module ima_back #(
   parameter int MAX_DIM = ima_pkg::MAX_DIM_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  ima_pkg::cfg_type   cfg,
   input  logic               cmd_valid,
   input  ima_pkg::cmd_type   cmd,
   output logic               cmd_pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output ima_pkg::rsp_type   rsp
);

   import ima_pkg::*;

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CRD_W  = $clog2(OUT_DEPTH + 1);

   function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] r,
                                                 input logic [IDX_W-1:0] c);
      return ADDR_W'(int'(r) * MAX_DIM + int'(c));
   endfunction

   // Sequencer
   logic             busy_ff, busy_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [CRD_W-1:0] credit_ff, credit_in;
   logic [DIM_W-1:0] n_rows, n_cols, n_inner;
   logic             last_i, last_j, last_k;
   logic             credit_ok;
   logic             beat_fire;
   logic             err_pop;
   logic             run_pop;
   logic             emit_issue;
   logic             out_pop;

   // Stores
   logic              ram_a_we, ram_b_we;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
   logic [VAL_W-1:0]  a_rd, b_rd;

   // Pipeline
   logic             s1_valid_ff, s1_first_ff, s1_emit_ff, s1_last_ff, s1_err_ff;
   logic [IDX_W-1:0] s1_row_ff, s1_col_ff;
   logic             s2_valid_ff, s2_first_ff, s2_emit_ff, s2_last_ff, s2_err_ff;
   logic [IDX_W-1:0] s2_row_ff, s2_col_ff;
   logic [VAL_W-1:0] b_sel, prod, term, term_ff, acc_ff, acc_sum;
   logic             out_push, out_full;
   rsp_type          out_word;
   logic [$bits(rsp_type)-1:0] out_bits;

   // Extent of the run in each loop
   always_comb begin
      n_rows  = cfg.rows_a;
      n_cols  = cfg.cols_a;
      n_inner = DIM_W'(1);
      case (cfg.op)
         OP_MUL: begin
            n_cols  = cfg.cols_b;
            n_inner = cfg.cols_a;
         end
         OP_TRANSPOSE: begin
            n_rows = cfg.cols_a;
            n_cols = cfg.rows_a;
         end
         default: begin
            n_rows = cfg.rows_a;
         end
      endcase
   end

   assign last_i = (DIM_W'(i_ff) + DIM_W'(1)) == n_rows;
   assign last_j = (DIM_W'(j_ff) + DIM_W'(1)) == n_cols;
   assign last_k = (DIM_W'(k_ff) + DIM_W'(1)) == n_inner;

   // Issue control: every emitted result holds an output slot until taken
   assign credit_ok  = credit_ff < CRD_W'(OUT_DEPTH);
   assign beat_fire  = busy_ff && (!last_k || credit_ok);
   assign cmd_pop    = cmd_valid && !busy_ff && ((cmd.kind != KIND_ERROR) || credit_ok);
   assign err_pop    = cmd_pop && (cmd.kind == KIND_ERROR);
   assign run_pop    = cmd_pop && (cmd.kind == KIND_RUN);
   assign emit_issue = (beat_fire && last_k) || err_pop;
   assign out_pop    = rsp_tvalid && rsp_tready;
   assign credit_in  = credit_ff + CRD_W'(emit_issue) - CRD_W'(out_pop);

   // Walk inner index, then column, then row
   always_comb begin
      busy_in = busy_ff;
      i_in    = i_ff;
      j_in    = j_ff;
      k_in    = k_ff;
      if (run_pop) begin
         busy_in = 1'b1;
         i_in    = '0;
         j_in    = '0;
         k_in    = '0;
      end else if (beat_fire) begin
         if (last_k) begin
            k_in = '0;
            if (last_j) begin
               j_in = '0;
               if (last_i) begin
                  i_in    = '0;
                  busy_in = 1'b0;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end else begin
            k_in = k_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         i_ff      <= '0;
         j_ff      <= '0;
         k_ff      <= '0;
         credit_ff <= '0;
      end else begin
         busy_ff   <= busy_in;
         i_ff      <= i_in;
         j_ff      <= j_in;
         k_ff      <= k_in;
         credit_ff <= credit_in;
      end
   end

   // Store addressing
   assign ram_a_we = cmd_pop && (cmd.kind == KIND_WRITE_A);
   assign ram_b_we = cmd_pop && (cmd.kind == KIND_WRITE_B);
   assign wr_addr  = addr_of(cmd.row, cmd.col);

   always_comb begin
      rd_addr_a = addr_of(i_ff, j_ff);
      rd_addr_b = addr_of(i_ff, j_ff);
      case (cfg.op)
         OP_MUL: begin
            rd_addr_a = addr_of(i_ff, k_ff);
            rd_addr_b = addr_of(k_ff, j_ff);
         end
         OP_TRANSPOSE: begin
            rd_addr_a = addr_of(j_ff, i_ff);
         end
         default: begin
            rd_addr_b = addr_of(i_ff, j_ff);
         end
      endcase
   end

   ima_ram #(
      .WIDTH (VAL_W),
      .DEPTH (DEPTH)
   ) u_store_a (
      .clock   (clock),
      .wr_en   (ram_a_we),
      .wr_addr (wr_addr),
      .wr_data (cmd.value),
      .rd_en   (beat_fire),
      .rd_addr (rd_addr_a),
      .rd_data (a_rd)
   );

   ima_ram #(
      .WIDTH (VAL_W),
      .DEPTH (DEPTH)
   ) u_store_b (
      .clock   (clock),
      .wr_en   (ram_b_we),
      .wr_addr (wr_addr),
      .wr_data (cmd.value),
      .rd_en   (beat_fire),
      .rd_addr (rd_addr_b),
      .rd_data (b_rd)
   );

   // Stage 1: tags travel alongside the store read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= beat_fire || err_pop;
      end
   end

   always_ff @(posedge clock) begin
      s1_first_ff <= err_pop || (k_ff == '0);
      s1_emit_ff  <= err_pop || last_k;
      s1_last_ff  <= err_pop || (last_i && last_j && last_k);
      s1_err_ff   <= err_pop;
      s1_row_ff   <= err_pop ? '0 : i_ff;
      s1_col_ff   <= err_pop ? '0 : j_ff;
   end

   // Form the term: sum, difference, copy or product
   assign b_sel = (cfg.op == OP_SCALE) ? cfg.scale : b_rd;
   assign prod  = a_rd * b_sel;

   always_comb begin
      case (cfg.op)
         OP_ADD:       term = a_rd + b_rd;
         OP_SUB:       term = a_rd - b_rd;
         OP_TRANSPOSE: term = a_rd;
         default:      term = prod;
      endcase
   end

   // Stage 2: accumulate over the inner index
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_first_ff <= s1_first_ff;
      s2_emit_ff  <= s1_emit_ff;
      s2_last_ff  <= s1_last_ff;
      s2_err_ff   <= s1_err_ff;
      s2_row_ff   <= s1_row_ff;
      s2_col_ff   <= s1_col_ff;
      term_ff     <= term;
   end

   assign acc_sum = s2_first_ff ? term_ff : acc_ff + term_ff;

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         acc_ff <= acc_sum;
      end
   end

   // Hand finished elements to the output queue
   assign out_push        = s2_valid_ff && s2_emit_ff;
   assign out_word.row    = s2_row_ff;
   assign out_word.col    = s2_col_ff;
   assign out_word.value  = s2_err_ff ? '0 : acc_sum;
   assign out_word.last   = s2_last_ff;
   assign out_word.status = s2_err_ff;

   ima_queue #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .din   (out_word),
      .pop   (out_pop),
      .dout  (out_bits),
      .valid (rsp_tvalid),
      .full  (out_full)
   );

   assign rsp = out_bits;

   // Credits never exceed the output queue depth
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= CRD_W'(OUT_DEPTH))
      else $error("output credit count above queue depth");

   // Credit scheme keeps the output queue from overflowing
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result pushed into full output queue");

   // Stores are never written in a cycle that also reads them for a run
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      (ram_a_we || ram_b_we) |-> !beat_fire)
      else $error("store write overlaps compute read");

   // Error beats always close their run as a single result
   a_err_single: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && s2_err_ff) |-> (s2_emit_ff && s2_last_ff))
      else $error("error result not marked last");

endmodule

// ===== src/integer_matrix_alu.sv =====
// Element writes: one word per cycle while the command queue has room; each is queued and then
//   written to its store when popped. Compute: while output credits last, one element per cycle
//   for add, subtract, transpose and scale, one per cols_a inner terms for multiply (one inner
//   product term per cycle through the shared multiplier); a dimension error gives one result.
// Reset (synchronous, active high) restores register defaults and empties queues and pipeline;
//   the A and B stores are not cleared and hold unknown data until written.
// ----------------------------------------------------------------------------
// integer_matrix_alu
// Integer matrix engine: add, subtract, multiply, transpose and scale over
// two element stores, with a command queue between classifier and executor.
// ----------------------------------------------------------------------------
module integer_matrix_alu #(
   parameter int MAX_DIM = ima_pkg::MAX_DIM_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [ima_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ima_pkg::VAL_W-1:0]      csr_wdata,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // row_index [2:0], col_index [5:3], element_value [37:6], zero [39:38]
   input  logic [ima_pkg::TDATA_W-1:0]    req_tdata,
   // action [1:0]
   input  logic [ima_pkg::ACT_W-1:0]      req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // out_row [2:0], out_col [5:3], out_value [37:6], zero [39:38]
   output logic [ima_pkg::TDATA_W-1:0]    rsp_tdata,
   output logic                           rsp_tlast,
   // status [0]
   output logic                           rsp_tuser
);

   import ima_pkg::*;

   localparam int CMD_W = $bits(cmd_type);

   cfg_type          cfg;
   cmd_type          cmd_in_word;
   cmd_type          cmd_out_word;
   logic [CMD_W-1:0] cmd_out_bits;
   logic             cmd_push, cmd_pop, cmd_valid, cmd_full;
   rsp_type          rsp;

   ima_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tuser),
      .req_row    (req_tdata[2:0]),
      .req_col    (req_tdata[5:3]),
      .req_value  (req_tdata[37:6]),
      .cmd_full   (cmd_full),
      .cmd_push   (cmd_push),
      .cmd        (cmd_in_word),
      .cfg        (cfg)
   );

   // Command queue between classifier and executor
   ima_queue #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .din   (cmd_in_word),
      .pop   (cmd_pop),
      .dout  (cmd_out_bits),
      .valid (cmd_valid),
      .full  (cmd_full)
   );

   assign cmd_out_word = cmd_out_bits;

   ima_back #(
      .MAX_DIM (MAX_DIM)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd_out_word),
      .cmd_pop    (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp        (rsp)
   );

   // Pack the result word
   assign rsp_tdata = {2'b00, rsp.value, rsp.col, rsp.row};
   assign rsp_tlast = rsp.last;
   assign rsp_tuser = rsp.status;

endmodule
